>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define JAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define JAC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define JAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define JAC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/jac_pkg.sv
`default_nettype none

package jac_pkg;

    localparam int AXIS_W      = 2;
    localparam int POS_W       = 11;
    localparam int NUM_W       = 8;
    localparam int DEN_W       = 8;
    localparam int DZ_W        = 10;
    localparam int SLEW_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int RAW_CENTER  = 2048;
    localparam int MAPPED_SPAN = 512;

    localparam logic [CFG_IDX_W-1:0] CFG_EMA_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_DEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW = 2'd3;

    localparam logic [NUM_W-1:0]  RST_EMA_NUM  = 8'd1;
    localparam logic [DEN_W-1:0]  RST_EMA_DEN  = 8'd4;
    localparam logic [DZ_W-1:0]   RST_DEADZONE = 10'd16;
    localparam logic [SLEW_W-1:0] RST_SLEW     = 11'd1024;

    typedef struct packed {
        logic [NUM_W-1:0]  ema_num;
        logic [DEN_W-1:0]  ema_den;
        logic [DZ_W-1:0]   deadzone;
        logic [SLEW_W-1:0] slew_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic add;
        logic map;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/jac_cfg.sv
`default_nettype none

module jac_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output jac_pkg::t_cfg                 o_cfg
);
    import jac_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EMA_NUM:  n_cfg.ema_num    = i_cfg_data[NUM_W-1:0];
                CFG_EMA_DEN:  n_cfg.ema_den    = i_cfg_data[DEN_W-1:0];
                CFG_DEADZONE: n_cfg.deadzone   = i_cfg_data[DZ_W-1:0];
                CFG_SLEW:     n_cfg.slew_limit = i_cfg_data[SLEW_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_num    <= RST_EMA_NUM;
            r_cfg.ema_den    <= RST_EMA_DEN;
            r_cfg.deadzone   <= RST_DEADZONE;
            r_cfg.slew_limit <= RST_SLEW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/jac_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module jac_ctrl #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  jac_pkg::t_dp_stat i_stat,
    output jac_pkg::t_dp_cmd  o_cmd
);
    import jac_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + NUM_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_MAP  = 3'd4;
    localparam logic [2:0] S_SLEW = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    t_dp_cmd          cmd;

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_cnt   = CNT_W'(PROD_W - 1);
                n_state = i_stat.first ? S_MAP : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ADD: begin
                cmd.add = 1'b1;
                n_state = S_MAP;
            end
            S_MAP: begin
                cmd.map = 1'b1;
                n_state = S_SLEW;
            end
            S_SLEW: begin
                // result register must be free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `JAC_ASSERT(a_out_from_slew, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_SLEW), "result beat appeared without finishing an item")
    `JAC_ASSERT(a_div_exit, i_clk, i_rst_n, (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_ADD), "divider did not hand over after its last step")
    `JAC_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, cmd.finish && r_out_valid && !i_out_ready, "result register overwritten while still held")

endmodule

`default_nettype wire

>>> rtl/jac_dp.sv
`default_nettype none

`include "assert_macros.svh"

module jac_dp #(
    parameter int NUM_AXES    = 3,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  jac_pkg::t_dp_cmd                  i_cmd,
    output jac_pkg::t_dp_stat                 o_stat,
    input  jac_pkg::t_cfg                     i_cfg,
    input  logic [jac_pkg::AXIS_W-1:0]        i_axis,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic [jac_pkg::AXIS_W-1:0]        o_axis_out,
    output logic signed [jac_pkg::POS_W-1:0]  o_position
);
    import jac_pkg::*;

    localparam int IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int PROD_W = SAMPLE_BITS + NUM_W;        // quotient magnitude bits
    localparam int MUL_W  = SAMPLE_BITS + NUM_W + 2;    // signed product bits
    localparam int SUM_W  = SAMPLE_BITS + NUM_W + 2;
    localparam int CW     = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2;

    localparam logic signed [CW-1:0] C_CENTER = CW'(RAW_CENTER);
    localparam logic signed [CW-1:0] C_SPAN   = CW'(MAPPED_SPAN);
    localparam logic signed [CW-1:0] C_NSPAN  = -CW'(MAPPED_SPAN);
    localparam logic signed [POS_W-1:0] P_SPAN  = POS_W'(MAPPED_SPAN);
    localparam logic signed [POS_W-1:0] P_NSPAN = -POS_W'(MAPPED_SPAN);

    // per-axis state
    logic                    r_started [NUM_AXES];
    logic [SAMPLE_BITS-1:0]  r_avg_mem [NUM_AXES];
    logic signed [POS_W-1:0] r_last_mem [NUM_AXES];

    // working registers for the item in flight
    logic [AXIS_W-1:0]       r_axis;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_in_range;
    logic                    r_first;
    logic [SAMPLE_BITS-1:0]  r_raw;
    logic [SAMPLE_BITS-1:0]  r_avg;
    logic signed [POS_W-1:0] r_last;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_dq;
    logic [DEN_W-1:0]        r_rem;
    logic [SAMPLE_BITS-1:0]  r_newavg;
    logic signed [POS_W-1:0] r_target;
    logic [AXIS_W-1:0]       r_out_axis;
    logic signed [POS_W-1:0] r_out_pos;

    logic [IDX_W-1:0]        in_idx;
    logic                    in_range;
    logic                    in_first;

    logic signed [SAMPLE_BITS:0] delta;
    logic signed [MUL_W-1:0]     prod;
    logic signed [MUL_W-1:0]     prod_abs;

    logic [DEN_W-1:0]        den;
    logic [DEN_W:0]          trial;
    logic                    trial_ge;

    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] sum;
    logic [SAMPLE_BITS-1:0]  sat_avg;

    logic [SAMPLE_BITS-1:0]  map_src;
    logic signed [CW-1:0]    c_ctr;
    logic signed [CW-1:0]    c_scl;
    logic signed [POS_W-1:0] c_clamp;
    logic signed [POS_W:0]   c_ext;
    logic signed [POS_W:0]   dz_ext;
    logic signed [POS_W-1:0] mapped;

    logic signed [POS_W:0]   step;
    logic signed [POS_W+1:0] step_ext;
    logic signed [POS_W+1:0] lim_ext;
    logic signed [POS_W+1:0] step_clamp;
    logic signed [POS_W-1:0] pos;

    assign in_idx   = IDX_W'(i_axis);
    assign in_range = (32'(i_axis) < NUM_AXES);
    assign in_first = !(in_range && r_started[in_idx]);

    assign o_stat.first = r_first;
    assign o_axis_out   = r_out_axis;
    assign o_position   = r_out_pos;

    // delta * numerator
    always_comb begin
        delta    = $signed({1'b0, r_raw}) - $signed({1'b0, r_avg});
        prod     = MUL_W'(delta) * $signed({{(MUL_W-NUM_W){1'b0}}, i_cfg.ema_num});
        prod_abs = prod[MUL_W-1] ? -prod : prod;
    end

    // restoring divide, one quotient bit per step
    always_comb begin
        den      = (i_cfg.ema_den == '0) ? DEN_W'(1) : i_cfg.ema_den;
        trial    = {r_rem, r_dq[PROD_W-1]};
        trial_ge = (trial >= {1'b0, den});
    end

    // apply signed quotient and saturate the average
    always_comb begin
        qs = $signed({2'b00, r_dq});
        if (r_neg) begin
            qs = -qs;
        end
        sum = $signed({{(SUM_W-SAMPLE_BITS){1'b0}}, r_avg}) + qs;
        if (sum[SUM_W-1]) begin
            sat_avg = '0;
        end else if (|sum[SUM_W-2:SAMPLE_BITS]) begin
            sat_avg = '1;
        end else begin
            sat_avg = sum[SAMPLE_BITS-1:0];
        end
    end

    // centre, scale toward zero, clamp, deadzone
    always_comb begin
        map_src = r_first ? r_raw : r_newavg;
        c_ctr   = $signed(CW'(map_src)) - C_CENTER;
        c_scl   = (c_ctr + (c_ctr[CW-1] ? CW'(3) : CW'(0))) >>> 2;
        if (c_scl > C_SPAN) begin
            c_clamp = P_SPAN;
        end else if (c_scl < C_NSPAN) begin
            c_clamp = P_NSPAN;
        end else begin
            c_clamp = c_scl[POS_W-1:0];
        end
        c_ext  = (POS_W+1)'(c_clamp);
        dz_ext = $signed({2'b00, i_cfg.deadzone});
        if (c_ext < dz_ext && c_ext > -dz_ext) begin
            mapped = '0;
        end else begin
            mapped = c_clamp;
        end
    end

    // slew limit toward the target; a first sample takes the target directly
    always_comb begin
        step     = (POS_W+1)'(r_target) - (POS_W+1)'(r_last);
        step_ext = (POS_W+2)'(step);
        lim_ext  = $signed({2'b00, i_cfg.slew_limit});
        if (step_ext > lim_ext) begin
            step_clamp = lim_ext;
        end else if (step_ext < -lim_ext) begin
            step_clamp = -lim_ext;
        end else begin
            step_clamp = step_ext;
        end
        if (r_first) begin
            pos = r_target;
        end else begin
            pos = r_last + step_clamp[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_axis     <= i_axis;
            r_idx      <= in_idx;
            r_in_range <= in_range;
            r_first    <= in_first;
            r_raw      <= i_sample;
            r_avg      <= r_avg_mem[in_idx];
            r_last     <= r_last_mem[in_idx];
        end
        if (i_cmd.mul) begin
            r_neg <= prod[MUL_W-1];
            r_dq  <= prod_abs[PROD_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (trial_ge) begin
                r_rem <= DEN_W'(trial - {1'b0, den});
                r_dq  <= {r_dq[PROD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DEN_W-1:0];
                r_dq  <= {r_dq[PROD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.add) begin
            r_newavg <= sat_avg;
        end else if (i_cmd.map) begin
            r_newavg <= map_src;
        end
        if (i_cmd.map) begin
            r_target <= mapped;
        end
        if (i_cmd.finish) begin
            r_out_axis <= r_axis;
            r_out_pos  <= pos;
        end
        if (i_cmd.finish && r_in_range) begin
            r_avg_mem[r_idx]  <= r_newavg;
            r_last_mem[r_idx] <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_started[i] <= 1'b0;
            end
        end else if (i_cmd.finish && r_in_range) begin
            r_started[r_idx] <= 1'b1;
        end
    end

    `JAC_ASSERT(a_pos_range, i_clk, i_rst_n,
        i_cmd.finish |-> (pos <= P_SPAN && pos >= P_NSPAN),
        "position outside the mapped span")
    `JAC_ASSERT(a_first_no_div, i_clk, i_rst_n,
        (i_cmd.div_step || i_cmd.add) |-> !r_first,
        "first sample routed through the average update")

endmodule

`default_nettype wire

>>> rtl/joystick_axis_conditioner_core.sv
`default_nettype none

// an item is loaded, multiplied by the smoothing numerator, divided by the
// denominator in a bit-serial divider (one quotient bit per cycle), added to the
// average, mapped and slew-limited; the first sample of an axis or an axis out of
// range skips the divide and add; a new item is taken only once the last finishes
// reset: synchronous active low, clears the per-axis started flags and loads the
// register defaults; the block takes an item in the first cycle after reset
module joystick_axis_conditioner_core #(
    parameter int NUM_AXES    = 3,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [jac_pkg::AXIS_W-1:0]         i_axis,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [jac_pkg::AXIS_W-1:0]         o_axis_out,
    output logic signed [jac_pkg::POS_W-1:0]   o_position,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import jac_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    jac_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    jac_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    jac_dp #(
        .NUM_AXES    (NUM_AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg      (cfg),
        .i_axis     (i_axis),
        .i_sample   (i_sample),
        .o_axis_out (o_axis_out),
        .o_position (o_position)
    );

endmodule

`default_nettype wire

>>> test/joystick_axis_conditioner_checker.sv
module joystick_axis_conditioner_checker #(
    parameter int NUM_AXES    = 3,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [jac_pkg::AXIS_W-1:0]            i_axis,
    input  logic [SAMPLE_BITS-1:0]                i_sample,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [jac_pkg::AXIS_W-1:0]            i_axis_out,
    input  logic signed [jac_pkg::POS_W-1:0]      i_position,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output int                                    o_pending,
    output int                                    o_errors
);

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic [jac_pkg::AXIS_W-1:0]       axis;
        logic signed [jac_pkg::POS_W-1:0] position;
    } t_position_beat;

    int ema_num;
    int ema_den;
    int deadzone;
    int slew_limit;

    logic axis_started [NUM_AXES];
    int   axis_average [NUM_AXES];
    int   axis_position [NUM_AXES];

    t_position_beat expected_positions [$];
    int             errors = 0;

    initial o_pending = 0;
    assign o_errors = errors;

    function automatic int map_to_position(input int raw);
        int c;
        c = ((raw - jac_pkg::RAW_CENTER) * jac_pkg::MAPPED_SPAN) / 2048;
        if (c > jac_pkg::MAPPED_SPAN) begin
            c = jac_pkg::MAPPED_SPAN;
        end else if (c < -jac_pkg::MAPPED_SPAN) begin
            c = -jac_pkg::MAPPED_SPAN;
        end
        if (c < deadzone && c > -deadzone) begin
            c = 0;
        end
        return c;
    endfunction

    // updates the per-axis filter state and returns the beat this sample causes
    function automatic t_position_beat condition_sample(
        input logic [jac_pkg::AXIS_W-1:0] ax,
        input logic [SAMPLE_BITS-1:0]     smp
    );
        int             raw;
        int             den;
        int             avg;
        int             target;
        int             step;
        int             pos;
        t_position_beat beat;
        raw = int'(smp);
        if (int'(ax) >= NUM_AXES) begin
            pos = map_to_position(raw);
        end else if (!axis_started[ax]) begin
            axis_started[ax] = 1'b1;
            axis_average[ax] = raw;
            pos = map_to_position(raw);
            axis_position[ax] = pos;
        end else begin
            den = (ema_den == 0) ? 1 : ema_den;
            avg = axis_average[ax] + ((raw - axis_average[ax]) * ema_num) / den;
            if (avg < 0) begin
                avg = 0;
            end else if (avg > SAMPLE_MAX) begin
                avg = SAMPLE_MAX;
            end
            axis_average[ax] = avg;
            target = map_to_position(avg);
            step = target - axis_position[ax];
            if (step > slew_limit) begin
                step = slew_limit;
            end else if (step < -slew_limit) begin
                step = -slew_limit;
            end
            pos = axis_position[ax] + step;
            axis_position[ax] = pos;
        end
        beat.axis     = ax;
        beat.position = pos[jac_pkg::POS_W-1:0];
        return beat;
    endfunction

    always @(posedge i_clk) begin
        t_position_beat want;
        if (!i_rst_n) begin
            ema_num    = int'(jac_pkg::RST_EMA_NUM);
            ema_den    = int'(jac_pkg::RST_EMA_DEN);
            deadzone   = int'(jac_pkg::RST_DEADZONE);
            slew_limit = int'(jac_pkg::RST_SLEW);
            for (int a = 0; a < NUM_AXES; a++) begin
                axis_started[a]  = 1'b0;
                axis_average[a]  = 0;
                axis_position[a] = 0;
            end
            expected_positions.delete();
        end else begin
            // compare before pushing so a beat never matches its own sample
            if (i_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: beat axis %0d position %0d arrived with nothing expected",
                             $time, i_axis_out, i_position);
                    errors++;
                end else begin
                    want = expected_positions.pop_front();
                    if (want.axis !== i_axis_out) begin
                        $display("%0t: axis_out expected %0d, actual %0d",
                                 $time, want.axis, i_axis_out);
                        errors++;
                    end
                    if (want.position !== i_position) begin
                        $display("%0t: position (axis %0d) expected %0d, actual %0d",
                                 $time, want.axis, $signed(want.position), i_position);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    jac_pkg::CFG_EMA_NUM:  ema_num    = int'(i_cfg_data[jac_pkg::NUM_W-1:0]);
                    jac_pkg::CFG_EMA_DEN:  ema_den    = int'(i_cfg_data[jac_pkg::DEN_W-1:0]);
                    jac_pkg::CFG_DEADZONE: deadzone   = int'(i_cfg_data[jac_pkg::DZ_W-1:0]);
                    jac_pkg::CFG_SLEW:     slew_limit = int'(i_cfg_data[jac_pkg::SLEW_W-1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_positions.push_back(condition_sample(i_axis, i_sample));
            end
        end
        o_pending <= expected_positions.size();
    end

endmodule

>>> test/joystick_axis_conditioner_core_tb.sv
module joystick_axis_conditioner_core_tb;

    localparam int NUM_AXES      = 3;
    localparam int SAMPLE_BITS   = 12;
    localparam int IDLE_LIMIT    = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 155;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY,
        RX_LONG_GAPS
    } t_rx_mode;

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    logic [jac_pkg::AXIS_W-1:0]          i_axis      = '0;
    logic [SAMPLE_BITS-1:0]              i_sample    = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic [jac_pkg::AXIS_W-1:0]          o_axis_out;
    logic signed [jac_pkg::POS_W-1:0]    o_position;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [jac_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [jac_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;

    int       pending;
    int       errors;
    int       burst_left    = 0;
    logic     steady        = 1'b0;
    logic     long_hold_req = 1'b0;
    logic     hold_done     = 1'b0;
    int       hold_left     = 0;
    t_rx_mode rx_mode       = RX_ALWAYS;
    int       mode_left     = 0;
    int       rx_tick       = 0;
    int       idle_cycles   = 0;
    int       walk [4]      = '{default: 2048};

    always #6 i_clk = ~i_clk;

    joystick_axis_conditioner_core #(
        .NUM_AXES    (NUM_AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_axis      (i_axis),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_axis_out  (o_axis_out),
        .o_position  (o_position),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    joystick_axis_conditioner_checker #(
        .NUM_AXES    (NUM_AXES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_axis      (i_axis),
        .i_sample    (i_sample),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_axis_out  (o_axis_out),
        .i_position  (o_position),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // receiver: its own stall pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        rx_tick++;
        if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 4));
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:    i_out_ready <= 1'b1;
                RX_COIN:      i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:    i_out_ready <= (rx_tick % 7) == 0;
                RX_MOSTLY:    i_out_ready <= $urandom_range(0, 7) != 0;
                RX_LONG_GAPS: i_out_ready <= (rx_tick % 40) >= 30;
                default:      i_out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_sample(input logic [jac_pkg::AXIS_W-1:0] ax,
                               input logic [SAMPLE_BITS-1:0] smp);
        i_in_valid <= 1'b1;
        i_axis     <= ax;
        i_sample   <= smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!steady) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_reg(input logic [jac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jac_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input int num, input int den, input int dz, input int slew);
        logic [2:0] junk;
        junk = 3'($urandom_range(0, 7));
        write_reg(jac_pkg::CFG_EMA_NUM, {junk, 8'(num)});
        junk = 3'($urandom_range(0, 7));
        write_reg(jac_pkg::CFG_EMA_DEN, {junk, 8'(den)});
        write_reg(jac_pkg::CFG_DEADZONE, {1'($urandom_range(0, 1)), 10'(dz)});
        write_reg(jac_pkg::CFG_SLEW, 11'(slew));
    endtask

    // all position beats back, then enough cycles for the block to go idle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [jac_pkg::AXIS_W-1:0] ax);
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            2, 3: v = 2048 + int'($urandom_range(0, 160)) - 80;
            4, 5, 6: begin
                // slow drift like a real stick
                walk[ax] = walk[ax] + int'($urandom_range(0, 400)) - 200;
                if (walk[ax] < 0) walk[ax] = 0;
                if (walk[ax] > 4095) walk[ax] = 4095;
                v = walk[ax];
            end
            default: v = $urandom_range(0, 4095);
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    initial begin
        int num;
        int den;
        int dz;
        int slew;
        logic [jac_pkg::AXIS_W-1:0] ax;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: first samples, out-of-range axis, deadzone edges
        send_sample(2'd0, 12'd0);
        send_sample(2'd1, 12'd4095);
        send_sample(2'd2, 12'd2048);
        send_sample(2'd3, 12'd1234);
        send_sample(2'd3, 12'd0);
        send_sample(2'd3, 12'd4095);
        send_sample(2'd2, 12'd2111);
        send_sample(2'd2, 12'd2112);
        send_sample(2'd2, 12'd1985);
        send_sample(2'd0, 12'd4095);
        send_sample(2'd1, 12'd0);
        wait_drained();

        // numerator above a zero denominator, frozen slew
        write_settings(255, 0, 0, 0);
        send_sample(2'd0, 12'd0);
        send_sample(2'd1, 12'd4095);
        send_sample(2'd3, 12'd2100);
        wait_drained();

        // deadzone beyond full scale, widest slew
        write_settings(200, 7, 1023, 2047);
        send_sample(2'd0, 12'd4095);
        send_sample(2'd1, 12'd0);
        send_sample(2'd3, 12'd4095);
        wait_drained();

        // heaviest smoothing, deadzone at full scale, one step per sample
        write_settings(1, 255, 512, 1);
        send_sample(2'd0, 12'd2048);
        send_sample(2'd2, 12'd4095);
        send_sample(2'd3, 12'd0);
        send_sample(2'd3, 12'd4095);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: write_settings(1, 1, 0, 2047);
                3: write_settings(255, 255, 1023, 1);
                5: write_settings(0, 0, 512, 0);
                default: begin
                    case ($urandom_range(0, 7))
                        0: num = 1;
                        1: num = 255;
                        2: num = 0;
                        default: num = $urandom_range(1, 255);
                    endcase
                    case ($urandom_range(0, 7))
                        0: den = 0;
                        1: den = $urandom_range(1, 255);
                        default: den = $urandom_range((num == 0) ? 1 : num, 255);
                    endcase
                    case ($urandom_range(0, 5))
                        0: dz = 0;
                        1: dz = 512;
                        2: dz = 1023;
                        3: dz = $urandom_range(513, 1023);
                        default: dz = $urandom_range(0, 64);
                    endcase
                    case ($urandom_range(0, 6))
                        0: slew = 0;
                        1: slew = 1;
                        2: slew = 2047;
                        3: slew = 1024;
                        4: slew = $urandom_range(1, 16);
                        default: slew = $urandom_range(1, 1024);
                    endcase
                    write_settings(num, den, dz, slew);
                end
            endcase
            steady = (p % 4) == 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver holds off while the sender keeps pushing
                if (p == 1 && n == 40) long_hold_req = 1'b1;
                ax = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, NUM_AXES - 1));
                send_sample(ax, pick_sample(ax));
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
